>>> rtl/tilp_pkg.sv
// Package for the tiled-to-linear pixel decoder: pixel record type,
// register indexes and field widths. No dependencies.
package tilp_pkg;

    localparam int COORD_W  = 19;
    localparam int GRAY_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TDATA_W  = 48;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE_8BPP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATED_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT     = 2'd2;

    localparam logic [15:0] COLS_DERIVE = 16'hFFFF;
    localparam logic [5:0]  LAST_BYTE_4BPP = 6'd31;
    localparam logic [5:0]  LAST_BYTE_8BPP = 6'd63;

    typedef struct packed {
        logic               image_done;
        logic               last_of_byte;
        logic               opaque;
        logic [GRAY_W-1:0]  gray;
        logic [COORD_W-1:0] pixel_y;
        logic [COORD_W-1:0] pixel_x;
    } pixel_t;

endpackage

>>> rtl/tiled_indexed_to_linear_pixels.sv
// Tiled 8x8 indexed pixel decoder (4 or 8 bits per pixel) to raster pixels.
// Depends on tilp_pkg.
//
// channel | dir | handshake          | payload
// s_*     | in  | s_tvalid/s_tready  | s_tdata[7:0] tile_byte
// m_*     | out | m_tvalid/m_tready  | m_tdata x,y,gray,opaque; m_tuser last_of_byte;
//         |     |                    | m_tlast image_done
// cfg_*   | in  | cfg_we             | cfg_index, cfg_wdata
//
// A byte is decoded in the cycle it is taken; its pixels go to an output
// register and a two-deep hold buffer. 8 bpp: one byte per cycle while the output
// accepts. 4 bpp: the second pixel waits in the hold buffer until the single
// output register takes it. s_tready depends only on the hold buffer being empty.
// Reset (rst_n low, async) clears position state and loads register defaults.
// A stalled output keeps its pixel; input stalls while the hold buffer is not empty.
module tiled_indexed_to_linear_pixels
    import tilp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] tile_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [18:0] pixel_x, [37:19] pixel_y, [45:38] gray, [46] opaque, [47] zero
    output logic [TDATA_W-1:0]    m_tdata,
    output logic                  m_tuser,   // [0] last_of_byte
    output logic                  m_tlast,   // image_done
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic        mode_reg, mode_next;
    logic [15:0] stated_reg, stated_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] cols_reg, cols_next;
    logic [5:0]  byte_reg, byte_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [15:0] done_reg, done_next;

    pixel_t      out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    pixel_t      hold_reg [2];
    pixel_t      hold_next [2];
    logic [1:0]  hold_cnt_reg, hold_cnt_next;

    logic        restart;
    logic        in_acc;
    logic        out_free;
    logic        active;
    logic        end_of_tile;
    logic        img_done;
    logic [1:0]  n_pix;
    logic [2:0]  yoff;
    logic [2:0]  xoff;
    logic [3:0]  lo_nib;
    logic [3:0]  hi_nib;
    logic [16:0] col_inc;
    pixel_t      pix0, pix1;

    // configuration writes; any known index starts a new image
    always_comb
    begin
        mode_next   = mode_reg;
        stated_next = stated_reg;
        count_next  = count_reg;
        restart     = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE_8BPP:
                begin
                    mode_next = cfg_wdata[0];
                    restart   = 1'b1;
                end
                REG_STATED_COLUMNS:
                begin
                    stated_next = cfg_wdata;
                    restart     = 1'b1;
                end
                REG_TILE_COUNT:
                begin
                    count_next = cfg_wdata;
                    restart    = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // grid width from the new register values
    always_comb
    begin
        priority if (stated_next != 16'd0 && stated_next != COLS_DERIVE)
            cols_next = stated_next;
        else if (count_next < 16'd16)
            cols_next = count_next;
        else if (count_next[4:0] == 5'd0)
            cols_next = 16'd32;
        else
            cols_next = 16'd16;
    end

    assign s_tready = (hold_cnt_reg == 2'd0);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // decode of the current byte
    assign active      = (cols_reg != 16'd0) && (done_reg < count_reg);
    assign end_of_tile = byte_reg >= (mode_reg ? LAST_BYTE_8BPP : LAST_BYTE_4BPP);
    assign img_done    = end_of_tile && ({1'b0, done_reg} + 17'd1 == {1'b0, count_reg});
    assign yoff        = mode_reg ? byte_reg[5:3] : byte_reg[4:2];
    assign xoff        = mode_reg ? byte_reg[2:0] : {byte_reg[1:0], 1'b0};
    assign lo_nib      = s_tdata[3:0];
    assign hi_nib      = s_tdata[7:4];
    assign n_pix       = !active ? 2'd0 : (mode_reg ? 2'd1 : 2'd2);

    always_comb
    begin
        pix0.pixel_x      = {col_reg, xoff};
        pix0.pixel_y      = {row_reg, yoff};
        pix1.pixel_x      = {col_reg, xoff[2:1], 1'b1};
        pix1.pixel_y      = {row_reg, yoff};
        pix1.gray         = {hi_nib, hi_nib};      // index * 17
        pix1.opaque       = (hi_nib != 4'd0);
        pix1.last_of_byte = 1'b1;
        pix1.image_done   = img_done;
        if (mode_reg)
        begin
            pix0.gray         = s_tdata;
            pix0.opaque       = (s_tdata != 8'd0);
            pix0.last_of_byte = 1'b1;
            pix0.image_done   = img_done;
        end
        else
        begin
            pix0.gray         = {lo_nib, lo_nib};
            pix0.opaque       = (lo_nib != 4'd0);
            pix0.last_of_byte = 1'b0;
            pix0.image_done   = 1'b0;
        end
    end

    // tile position
    assign col_inc = {1'b0, col_reg} + 17'd1;

    always_comb
    begin
        byte_next = byte_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        done_next = done_reg;
        if (restart)
        begin
            byte_next = '0;
            col_next  = '0;
            row_next  = '0;
            done_next = '0;
        end
        else if (in_acc && active)
        begin
            if (end_of_tile)
            begin
                byte_next = '0;
                done_next = done_reg + 16'd1;
                if (col_inc >= {1'b0, cols_reg})
                begin
                    col_next = '0;
                    row_next = row_reg + 16'd1;
                end
                else
                begin
                    col_next = col_inc[15:0];
                end
            end
            else
            begin
                byte_next = byte_reg + 6'd1;
            end
        end
    end

    // output register and hold buffer
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        hold_next[0]   = hold_reg[0];
        hold_next[1]   = hold_reg[1];
        hold_cnt_next  = hold_cnt_reg;
        if (hold_cnt_reg != 2'd0)
        begin
            if (out_free)
            begin
                out_next       = hold_reg[0];
                out_valid_next = 1'b1;
                hold_next[0]   = hold_reg[1];
                hold_cnt_next  = hold_cnt_reg - 2'd1;
            end
        end
        else if (in_acc && n_pix != 2'd0)
        begin
            if (out_free)
            begin
                out_next       = pix0;
                out_valid_next = 1'b1;
                hold_next[0]   = pix1;
                hold_cnt_next  = n_pix - 2'd1;
            end
            else
            begin
                hold_next[0]  = pix0;
                hold_next[1]  = pix1;
                hold_cnt_next = n_pix;
            end
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            stated_reg    <= 16'd0;
            count_reg     <= 16'd1;
            cols_reg      <= 16'd1;
            byte_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
            hold_cnt_reg  <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            stated_reg    <= stated_next;
            count_reg     <= count_next;
            if (restart)
                cols_reg <= cols_next;
            byte_reg      <= byte_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            hold_cnt_reg  <= hold_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        hold_reg[0] <= hold_next[0];
        hold_reg[1] <= hold_next[1];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.opaque, out_reg.gray, out_reg.pixel_y, out_reg.pixel_x};
    assign m_tuser  = out_reg.last_of_byte;
    assign m_tlast  = out_reg.image_done;

endmodule

>>> rtl/tilp_checker.sv
// Port-level checks for the tiled-to-linear pixel decoder, bound to the top
// level. Depends on tilp_pkg.
module tilp_checker
    import tilp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_W-1:0]    m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast
);

    // a stalled output request keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output request changed while stalled");

    // end of image is always the final pixel of its byte
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("image_done without last_of_byte");

    // low nibble pixel sits on an even column and its partner follows at once
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tuser |-> !m_tdata[0] ##1 (m_tvalid && m_tuser))
        else $error("nibble pair broken");

    // hold buffer drains while the output keeps accepting
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_tready && m_tready) ##1 (!s_tready && m_tready) |=> s_tready)
        else $error("input held off too long");

endmodule

bind tiled_indexed_to_linear_pixels tilp_checker u_tilp_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for tiled_indexed_to_linear_pixels: streams tile bytes,
// predicts every raster pixel and compares the output stream field by field.
// Depends on tilp_pkg and the decoder RTL.
module tb_top;
    import tilp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;   // outside the register map
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int BYTE_TARGET    = 1850;
    localparam pixel_t NO_PIX     = '0;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [15:0]           val;
        bit                    typed;
        int                    n;
        pixel_t                e0;
        pixel_t                e1;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // decoder shadow state
    logic        cfg_8bpp;
    logic [15:0] cfg_cols;
    logic [15:0] cfg_tiles;
    logic [5:0]  byte_pos;
    logic [15:0] col_pos;
    logic [15:0] row_pos;
    logic [15:0] tiles_done;
    logic [15:0] grid_cols;

    pixel_t pending_pixels[$];
    int     mismatch_count = 0;
    int     fed_count = 0;      // bytes that produced pixels
    int     tx_idle_pct = 22;
    int     rx_idle_pct = 68;
    int     quiet_cycles = 0;
    int     hold_left = 0;
    bit     hold_req = 1'b0;
    bit     hold_done = 1'b0;

    tiled_indexed_to_linear_pixels u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic pixel_t pix(input logic [18:0] x, input logic [18:0] y,
                                   input logic [7:0] g, input logic op,
                                   input logic lst, input logic dn);
        pixel_t p;
        p.pixel_x      = x;
        p.pixel_y      = y;
        p.gray         = g;
        p.opaque       = op;
        p.last_of_byte = lst;
        p.image_done   = dn;
        return p;
    endfunction

    // any write to a mapped register starts a new image
    function void restart_image();
        byte_pos   = '0;
        col_pos    = '0;
        row_pos    = '0;
        tiles_done = '0;
        if (cfg_cols != 16'd0 && cfg_cols != COLS_DERIVE)
            grid_cols = cfg_cols;
        else if (cfg_tiles < 16'd16)
            grid_cols = cfg_tiles;
        else if (cfg_tiles[4:0] == 5'd0)
            grid_cols = 16'd32;
        else
            grid_cols = 16'd16;
    endfunction

    // returns the number of pixels the byte makes and advances the tile position
    function automatic int decode_byte(input logic [7:0] b, output pixel_t p0,
                                       output pixel_t p1);
        logic [5:0]  last_pos;
        logic        eot;
        logic        fin;
        logic [18:0] bx;
        logic [18:0] by;
        logic [18:0] x0;
        logic [18:0] y0;
        logic [3:0]  lo;
        logic [3:0]  hi;
        int          n;
        p0 = NO_PIX;
        p1 = NO_PIX;
        if (grid_cols == 16'd0 || tiles_done >= cfg_tiles)
            return 0;
        last_pos = cfg_8bpp ? LAST_BYTE_8BPP : LAST_BYTE_4BPP;
        eot = (byte_pos >= last_pos);
        fin = eot && ({1'b0, tiles_done} + 17'd1 == {1'b0, cfg_tiles});
        bx  = {col_pos, 3'b000};
        by  = {row_pos, 3'b000};
        if (cfg_8bpp)
        begin
            p0 = pix(bx + 19'(byte_pos[2:0]), by + 19'(byte_pos[5:3]), b, b != 8'd0,
                     1'b1, fin);
            n = 1;
        end
        else
        begin
            x0 = bx + 19'({byte_pos[1:0], 1'b0});
            y0 = by + 19'(byte_pos[4:2]);
            lo = b[3:0];
            hi = b[7:4];
            p0 = pix(x0, y0, 8'(lo * 17), lo != 4'd0, 1'b0, 1'b0);
            p1 = pix(x0 + 19'd1, y0, 8'(hi * 17), hi != 4'd0, 1'b1, fin);
            n = 2;
        end
        if (eot)
        begin
            byte_pos   = '0;
            tiles_done = tiles_done + 16'd1;
            col_pos    = col_pos + 16'd1;
            if (col_pos >= grid_cols)
            begin
                col_pos = '0;
                row_pos = row_pos + 16'd1;
            end
        end
        else
            byte_pos = byte_pos + 6'd1;
        return n;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        // ignored bytes leave nothing to wait on; let the pipe settle
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE_8BPP:      cfg_8bpp = val[0];
            REG_STATED_COLUMNS: cfg_cols = val;
            REG_TILE_COUNT:     cfg_tiles = val;
            default:            return;
        endcase
        restart_image();
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed, input int n_typed,
                             input pixel_t t0, input pixel_t t1);
        pixel_t p0;
        pixel_t p1;
        int     n;
        if (fed_count < BYTE_TARGET / 3)
        begin
            tx_idle_pct = 22;
            rx_idle_pct = 68;
        end
        else if (fed_count < 2 * BYTE_TARGET / 3)
        begin
            tx_idle_pct = 68;
            rx_idle_pct = 22;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n = decode_byte(b, p0, p1);
        if (n > 0)
            fed_count++;
        if (typed)
        begin
            n  = n_typed;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            pending_pixels.push_back(p0);
        if (n > 1)
            pending_pixels.push_back(p1);
    endtask

    task automatic run_image(input logic mode, input logic [15:0] stated,
                             input logic [15:0] count, input int nbytes,
                             input bit press);
        write_reg(REG_MODE_8BPP, {15'd0, mode});
        write_reg(REG_STATED_COLUMNS, stated);
        write_reg(REG_TILE_COUNT, count);
        // long receiver hold-off starts with the first bytes of this image
        if (press)
            hold_req <= 1'b1;
        for (int i = 0; i < nbytes; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0, 0, NO_PIX, NO_PIX);
    endtask

    task automatic check_field(input string what, input logic [31:0] e,
                               input logic [31:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, e, a);
            mismatch_count++;
        end
    endtask

    // receiver: random back-pressure plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        pixel_t seen;
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = pixel_t'({m_tlast, m_tuser, m_tdata[46:0]});
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel, expected none, actual %h", $time, seen);
                mismatch_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("pixel_x", want.pixel_x, seen.pixel_x);
                check_field("pixel_y", want.pixel_y, seen.pixel_y);
                check_field("gray", want.gray, seen.gray);
                check_field("opaque", want.opaque, seen.opaque);
                check_field("last_of_byte", want.last_of_byte, seen.last_of_byte);
                check_field("image_done", want.image_done, seen.image_done);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        row_t        rows[$];
        logic        mode;
        logic [15:0] stated;
        logic [15:0] count;
        int          full;
        int          len;
        int          nbytes;

        cfg_8bpp  = 1'b0;
        cfg_cols  = 16'd0;
        cfg_tiles = 16'd1;
        restart_image();

        // reset state: 4 bpp, one tile, one column
        rows.push_back('{ROW_BYTE, REG_NONE, 16'h0000, 1'b1, 2,
                         pix(19'd0, 19'd0, 8'd0, 1'b0, 1'b0, 1'b0),
                         pix(19'd1, 19'd0, 8'd0, 1'b0, 1'b1, 1'b0)});
        rows.push_back('{ROW_BYTE, REG_NONE, 16'h00FF, 1'b1, 2,
                         pix(19'd2, 19'd0, 8'd255, 1'b1, 1'b0, 1'b0),
                         pix(19'd3, 19'd0, 8'd255, 1'b1, 1'b1, 1'b0)});
        rows.push_back('{ROW_BYTE, REG_NONE, 16'h001E, 1'b0, 0, NO_PIX, NO_PIX});
        // unmapped index: no restart, position carries on
        rows.push_back('{ROW_CFG, REG_NONE, 16'hFFFF, 1'b0, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_BYTE, REG_NONE, 16'h00A5, 1'b0, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_BYTE, REG_NONE, 16'h005A, 1'b0, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_CFG, REG_MODE_8BPP, 16'h0001, 1'b0, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_BYTE, REG_NONE, 16'h0000, 1'b1, 1,
                         pix(19'd0, 19'd0, 8'd0, 1'b0, 1'b1, 1'b0), NO_PIX});
        rows.push_back('{ROW_BYTE, REG_NONE, 16'h00FF, 1'b1, 1,
                         pix(19'd1, 19'd0, 8'd255, 1'b1, 1'b1, 1'b0), NO_PIX});
        rows.push_back('{ROW_BYTE, REG_NONE, 16'h0080, 1'b0, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_BYTE, REG_NONE, 16'h0001, 1'b0, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_CFG, REG_STATED_COLUMNS, 16'hFFFF, 1'b0, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_BYTE, REG_NONE, 16'h007F, 1'b0, 0, NO_PIX, NO_PIX});
        // zero tiles: grid derives to zero, bytes dropped
        rows.push_back('{ROW_CFG, REG_TILE_COUNT, 16'h0000, 1'b0, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_BYTE, REG_NONE, 16'h00FF, 1'b1, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_BYTE, REG_NONE, 16'h0055, 1'b1, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_CFG, REG_STATED_COLUMNS, 16'h0005, 1'b0, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_BYTE, REG_NONE, 16'h00AA, 1'b1, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_CFG, REG_TILE_COUNT, 16'hFFFF, 1'b0, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_CFG, REG_STATED_COLUMNS, 16'h0000, 1'b0, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_BYTE, REG_NONE, 16'h0033, 1'b0, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_CFG, REG_MODE_8BPP, 16'h0000, 1'b0, 0, NO_PIX, NO_PIX});
        rows.push_back('{ROW_BYTE, REG_NONE, 16'h00C3, 1'b0, 0, NO_PIX, NO_PIX});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_reg(rows[i].idx, rows[i].val);
            else
                send_byte(rows[i].val[7:0], rows[i].typed, rows[i].n, rows[i].e0,
                          rows[i].e1);
        end

        // derived width 32: 33 tiles to see the row wrap, then abandon the image;
        // the receiver holds off for a long stretch at the start
        run_image(1'b0, COLS_DERIVE, 16'd96, 33 * 32 + 5, 1'b1);
        // derived width 16: full image of 17 tiles plus trailing bytes
        run_image(1'b0, 16'd0, 16'd17, 17 * 32 + 3, 1'b0);

        while (fed_count < BYTE_TARGET)
        begin
            mode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 6))
                0:       stated = 16'd0;
                1:       stated = COLS_DERIVE;
                2:       stated = 16'd1;
                3:       stated = 16'd2;
                4:       stated = 16'd65534;
                default: stated = 16'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0:       count = 16'd0;
                1:       count = 16'hFFFF;
                default: count = 16'($urandom_range(1, 4));
            endcase
            full = int'(count) * (mode ? 64 : 32);
            len  = (full > 200) ? 200 : full;
            if (count == 16'd0)
                nbytes = 5;
            else if ($urandom_range(0, 3) == 0)
                nbytes = $urandom_range(1, len);
            else
                nbytes = len + $urandom_range(0, 4);
            run_image(mode, stated, count, nbytes, 1'b0);
        end

        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
rtl/tilp_pkg.sv
rtl/tiled_indexed_to_linear_pixels.sv
rtl/tilp_checker.sv
dv/tb_top.sv
